[sv/acg_pkg.sv]
`default_nettype none

package acg_pkg;

  // Table geometry.
  localparam int STOP_COUNT    = 9;
  localparam int SEG_COUNT     = STOP_COUNT - 1;
  localparam int CH_COUNT      = 6;
  localparam int ALT_FRAC_BITS = 4;
  localparam int ALT_W         = 12;
  localparam int DEG_W         = 8;
  localparam int STOP_W        = 4;
  localparam int SEG_W         = 3;

  // Datapath widths: offset and span stay within 320, products within 17 bits.
  localparam int OFF_W  = 9;
  localparam int P_W    = 17;
  localparam int RCP_W  = 13;
  localparam int RCP_SH = 17;

  // Table selector values.
  localparam logic TBL_EVENING = 1'b0;
  localparam logic TBL_MORNING = 1'b1;

  typedef struct packed {
    logic signed [ALT_W-1:0] altitude;
    logic                    is_morning;
  } in_req_t;

  typedef struct packed {
    logic [15:0] background_color;
    logic [15:0] text_color;
  } out_req_t;

  // Segment choice handed from the search stage to the channel lanes.
  typedef struct packed {
    logic             morning;
    logic [SEG_W-1:0] seg;
    logic [OFF_W-1:0] off;
  } seg_sel_t;

  // Per-stage load enables of the channel lanes.
  typedef struct packed {
    logic mul;
    logic rcp;
    logic fix;
  } lane_en_t;

  // Stop altitudes in whole degrees, evening table first.
  localparam logic signed [DEG_W-1:0] STOP_DEG [2][STOP_COUNT] = '{
    '{8'sd45, 8'sd25, 8'sd12, 8'sd4, 8'sd0, -8'sd2, -8'sd6, -8'sd12, -8'sd25},
    '{-8'sd25, -8'sd12, -8'sd6, -8'sd2, 8'sd0, 8'sd4, 8'sd12, 8'sd25, 8'sd45}
  };

  // Stop colors: background r, g, b then text r, g, b.
  localparam logic [7:0] STOP_CH [2][STOP_COUNT][CH_COUNT] = '{
    '{
      '{8'hF8, 8'hDE, 8'hB6, 8'h8C, 8'h3F, 8'h1F},
      '{8'hFA, 8'hDD, 8'hA4, 8'h9A, 8'h48, 8'h28},
      '{8'hF8, 8'hD2, 8'hA8, 8'hA0, 8'h4C, 8'h2C},
      '{8'hF6, 8'hC5, 8'hA2, 8'hA0, 8'h4C, 8'h2C},
      '{8'hF7, 8'hC5, 8'hB1, 8'hA0, 8'h4C, 8'h2C},
      '{8'hB5, 8'h9C, 8'hB0, 8'h5A, 8'h46, 8'h70},
      '{8'h5C, 8'h7A, 8'hA8, 8'hD3, 8'hE5, 8'hFD},
      '{8'h1F, 8'h2D, 8'h4D, 8'h95, 8'hB5, 8'hD9},
      '{8'h06, 8'h13, 8'h1F, 8'h90, 8'hCF, 8'hEF}
    },
    '{
      '{8'h06, 8'h13, 8'h1F, 8'h90, 8'hCF, 8'hEF},
      '{8'h0F, 8'h1E, 8'h36, 8'h7A, 8'hA8, 8'hD0},
      '{8'h3D, 8'h5C, 8'h8C, 8'hC5, 8'hD5, 8'hEE},
      '{8'h9D, 8'hB8, 8'hDC, 8'h50, 8'h65, 8'h90},
      '{8'hFD, 8'hED, 8'hA8, 8'hDB, 8'h60, 8'h28},
      '{8'hFB, 8'hE5, 8'hAA, 8'hC4, 8'h52, 8'h30},
      '{8'hFB, 8'hE0, 8'hAA, 8'hA0, 8'h4C, 8'h2C},
      '{8'hFA, 8'hDD, 8'hA4, 8'h9A, 8'h48, 8'h28},
      '{8'hF8, 8'hDE, 8'hB6, 8'h8C, 8'h3F, 8'h1F}
    }
  };

  // Segment spans in 1/16 degree, absolute value.
  localparam logic [OFF_W-1:0] SEG_DEN [2][SEG_COUNT] = '{
    '{9'd320, 9'd208, 9'd128, 9'd64, 9'd32, 9'd64, 9'd96, 9'd208},
    '{9'd208, 9'd96, 9'd64, 9'd32, 9'd64, 9'd128, 9'd208, 9'd320}
  };

  // Reciprocals floor(2^17 / span); the estimate is low by at most one.
  localparam logic [RCP_W-1:0] SEG_RCP [2][SEG_COUNT] = '{
    '{13'd409, 13'd630, 13'd1024, 13'd2048, 13'd4096, 13'd2048, 13'd1365, 13'd630},
    '{13'd630, 13'd1365, 13'd2048, 13'd4096, 13'd2048, 13'd1024, 13'd630, 13'd409}
  };

  // Stop altitude in 1/16 degree.
  function automatic logic signed [ALT_W-1:0] stop_alt(input logic morning,
                                                       input logic [STOP_W-1:0] idx);
    logic signed [ALT_W-1:0] ext;
    ext = ALT_W'(STOP_DEG[morning][idx]);
    return ext <<< ALT_FRAC_BITS;
  endfunction

endpackage

`default_nettype wire

[sv/acg_seg_find.sv]
`default_nettype none

module acg_seg_find (
  input  logic              clk_i,
  input  logic              en_i,
  input  acg_pkg::in_req_t  req_i,
  output acg_pkg::seg_sel_t sel_o
);
  import acg_pkg::*;

  logic [SEG_COUNT-1:0]    hit;
  logic                    found;
  logic [SEG_W-1:0]        seg_hit;
  logic signed [ALT_W-1:0] a1_sel;
  logic signed [ALT_W-1:0] a2_sel;
  logic signed [ALT_W:0]   off_raw;
  logic signed [ALT_W-1:0] e0;
  logic signed [ALT_W-1:0] e1;
  logic signed [ALT_W-1:0] e_lo;
  logic                    clamp_first;
  seg_sel_t                sel_d;
  seg_sel_t                sel_q;

  // Test every segment's closed span in parallel.
  always_comb begin
    for (int i = 0; i < SEG_COUNT; i++) begin
      logic signed [ALT_W-1:0] a1;
      logic signed [ALT_W-1:0] a2;
      a1 = stop_alt(req_i.is_morning, STOP_W'(i));
      a2 = stop_alt(req_i.is_morning, STOP_W'(i + 1));
      if (a1 <= a2) begin
        hit[i] = (req_i.altitude >= a1) && (req_i.altitude <= a2);
      end else begin
        hit[i] = (req_i.altitude >= a2) && (req_i.altitude <= a1);
      end
    end
  end

  // The earliest segment in table order wins.
  always_comb begin
    found   = 1'b0;
    seg_hit = '0;
    for (int i = 0; i < SEG_COUNT; i++) begin
      if (!found && hit[i]) begin
        found   = 1'b1;
        seg_hit = SEG_W'(i);
      end
    end
  end

  // Offset from the segment's first stop, measured toward its second stop.
  always_comb begin
    a1_sel = stop_alt(req_i.is_morning, {1'b0, seg_hit});
    a2_sel = stop_alt(req_i.is_morning, {1'b0, seg_hit} + STOP_W'(1));
    if (a2_sel < a1_sel) begin
      off_raw = (ALT_W+1)'(a1_sel) - (ALT_W+1)'(req_i.altitude);
    end else begin
      off_raw = (ALT_W+1)'(req_i.altitude) - (ALT_W+1)'(a1_sel);
    end
  end

  // Out of range: pick the end stop nearer in altitude.
  always_comb begin
    e0   = stop_alt(req_i.is_morning, '0);
    e1   = stop_alt(req_i.is_morning, STOP_W'(STOP_COUNT - 1));
    e_lo = (e0 < e1) ? e0 : e1;
    if (req_i.altitude < e_lo) begin
      clamp_first = (e0 <= e1);
    end else begin
      clamp_first = (e0 >= e1);
    end
  end

  // The last stop is the far end of the last segment.
  always_comb begin
    sel_d.morning = req_i.is_morning;
    if (found) begin
      sel_d.seg = seg_hit;
      sel_d.off = off_raw[OFF_W-1:0];
    end else if (clamp_first) begin
      sel_d.seg = '0;
      sel_d.off = '0;
    end else begin
      sel_d.seg = SEG_W'(SEG_COUNT - 1);
      sel_d.off = SEG_DEN[req_i.is_morning][SEG_COUNT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel_q <= sel_d;
    end
  end

  assign sel_o = sel_q;

endmodule

`default_nettype wire

[sv/acg_lerp_lane.sv]
`default_nettype none

module acg_lerp_lane #(
  parameter int CH_IDX = 0
) (
  input  logic              clk_i,
  input  acg_pkg::lane_en_t en_i,
  input  acg_pkg::seg_sel_t sel_i,
  output logic [7:0]        chan_o
);
  import acg_pkg::*;

  logic [7:0]       ca;
  logic [7:0]       cb;
  logic signed [8:0] diff;
  logic [7:0]       mag;
  logic [P_W-1:0]   p_d;

  logic [7:0]       ca2_q;
  logic             neg2_q;
  logic [P_W-1:0]   p2_q;
  logic [OFF_W-1:0] den2_q;
  logic [RCP_W-1:0] rcp2_q;

  logic [P_W+RCP_W-1:0] prod;

  logic [7:0]       ca3_q;
  logic             neg3_q;
  logic [P_W-1:0]   p3_q;
  logic [OFF_W-1:0] den3_q;
  logic [7:0]       q3_q;

  logic [P_W:0]     back;
  logic [P_W:0]     rem;
  logic [7:0]       quo;
  logic [7:0]       chan_d;
  logic [7:0]       chan_q;

  // Stage one: channel step magnitude times offset.
  always_comb begin
    ca   = STOP_CH[sel_i.morning][{1'b0, sel_i.seg}][CH_IDX];
    cb   = STOP_CH[sel_i.morning][{1'b0, sel_i.seg} + STOP_W'(1)][CH_IDX];
    diff = $signed({1'b0, cb}) - $signed({1'b0, ca});
    mag  = diff[8] ? 8'(-diff) : diff[7:0];
    p_d  = P_W'(mag) * P_W'(sel_i.off);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      ca2_q  <= ca;
      neg2_q <= diff[8];
      p2_q   <= p_d;
      den2_q <= SEG_DEN[sel_i.morning][sel_i.seg];
      rcp2_q <= SEG_RCP[sel_i.morning][sel_i.seg];
    end
  end

  // Stage two: quotient estimate through the span's reciprocal.
  assign prod = (P_W+RCP_W)'(p2_q) * (P_W+RCP_W)'(rcp2_q);

  always_ff @(posedge clk_i) begin
    if (en_i.rcp) begin
      ca3_q  <= ca2_q;
      neg3_q <= neg2_q;
      p3_q   <= p2_q;
      den3_q <= den2_q;
      q3_q   <= prod[RCP_SH+7:RCP_SH];
    end
  end

  // Stage three: one correction step, then apply the signed step.
  always_comb begin
    back = (P_W+1)'(q3_q) * (P_W+1)'(den3_q);
    rem  = (P_W+1)'(p3_q) - back;
    quo  = (rem >= (P_W+1)'(den3_q)) ? q3_q + 8'd1 : q3_q;
    chan_d = neg3_q ? ca3_q - quo : ca3_q + quo;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.fix) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

`default_nettype wire

[sv/altitude_color_gradient.sv]
// Each accepted request is registered in every stage listed below before its result reaches out_data_o.
// Throughput: one request per cycle; a stall on the output only holds stages that are full.
// Stages: segment search, step times offset, reciprocal multiply, correction and pack.
// Reset clears the stage valid bits only; the datapath registers are not reset.
`default_nettype none

module altitude_color_gradient (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  acg_pkg::in_req_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output acg_pkg::out_req_t out_data_o
);
  import acg_pkg::*;

  logic       v1_q, v2_q, v3_q, v4_q;
  logic       en1, en2, en3, en4;
  lane_en_t   lane_en;
  seg_sel_t   sel;
  logic [7:0] chan [CH_COUNT];

  // A stage loads when it is empty or its content moves on.
  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  assign lane_en.mul = en2;
  assign lane_en.rcp = en3;
  assign lane_en.fix = en4;

  // Valid bits travel with the request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  acg_seg_find u_seg_find (
    .clk_i (clk_i),
    .en_i  (en1),
    .req_i (in_data_i),
    .sel_o (sel)
  );

  // One lane per color channel.
  for (genvar k = 0; k < CH_COUNT; k++) begin : g_lane
    acg_lerp_lane #(
      .CH_IDX (k)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (lane_en),
      .sel_i  (sel),
      .chan_o (chan[k])
    );
  end

  // Pack both colors as RGB565.
  assign out_valid_o = v4_q;
  assign out_data_o.background_color = {chan[0][7:3], chan[1][7:2], chan[2][7:3]};
  assign out_data_o.text_color       = {chan[3][7:3], chan[4][7:2], chan[5][7:3]};

endmodule

`default_nettype wire
